// ===== rtl/core/reversed_z_depth_to_meters_macros.svh =====
`ifndef REVERSED_Z_DEPTH_TO_METERS_MACROS_SVH
`define REVERSED_Z_DEPTH_TO_METERS_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RZDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RZDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rzdm_pkg.sv =====
package rzdm_pkg;

    localparam logic [31:0] NEAR_RESET = 32'd65536;
    localparam logic [31:0] FAR_RESET  = 32'd655360000;

    // bit patterns of 1.0e-5f (magnitude) and of 1.0f + 1.0e-5f
    localparam logic [30:0] NEG_LIMIT = 31'h3727C5AC;
    localparam logic [31:0] POS_LIMIT = 32'h3F800054;

    localparam logic [31:0] SAT_Q16 = 32'hFFFFFFFF;

    // one divider cell per quotient bit
    localparam int QUO_W = 32;

    localparam logic [0:0] REG_NEAR = 1'b0;
    localparam logic [0:0] REG_FAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DEPTH  = 2'd1,
        ST_CLIP   = 2'd2,
        ST_METRIC = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pix;

    typedef struct packed {
        t_pix             pix;
        t_status          status;
        logic             sat;
        logic [62:0]      den;
        logic [63:0]      rem;
        logic [QUO_W-1:0] quo;
        logic [1:0]       bits;
    } t_div_beat;

    typedef struct packed {
        t_pix        pix;
        t_status     status;
        logic [31:0] metres;
    } t_res;

endpackage

// ===== rtl/core/rzdm_in_if.sv =====
interface rzdm_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
    logic [31:0] depth_word;
    logic        last_in;

    modport source (
        output valid, blue_in, green_in, red_in, depth_word, last_in,
        input  ready
    );
    modport sink (
        input  valid, blue_in, green_in, red_in, depth_word, last_in,
        output ready
    );
endinterface

// ===== rtl/core/rzdm_out_if.sv =====
interface rzdm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [31:0] depth_metres;
    logic [1:0]  status;
    logic        last_out;

    modport source (
        output valid, red_out, green_out, blue_out, depth_metres, status, last_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, depth_metres, status, last_out,
        output ready
    );
endinterface

// ===== rtl/core/rzdm_front.sv =====
`include "reversed_z_depth_to_meters_macros.svh"

module rzdm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [7:0]           i_blue,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_red,
    input  logic [31:0]          i_depth_word,
    input  logic                 i_last,
    input  logic [31:0]          i_near,
    input  logic [31:0]          i_far,
    output logic                 o_valid,
    output rzdm_pkg::t_div_beat  o_beat
);

    // decode of the float word
    logic [7:0]         ex;
    logic [23:0]        man;
    logic [4:0]         rs1;
    logic [23:0]        man_sh;
    logic [31:0]        mag;
    logic signed [32:0] d_q30;
    logic               clip_bad;
    rzdm_pkg::t_status  st_a;

    always_comb begin
        ex     = i_depth_word[30:23];
        man    = {ex != 8'd0, i_depth_word[22:0]};
        rs1    = 5'(8'd119 - ex);
        man_sh = man >> rs1;
        mag    = '0;
        if (ex >= 8'd120) begin
            mag = {8'd0, man} << ex[2:0];
        end else if (ex >= 8'd96) begin
            // round half away: (man + 2^(rs-1)) >> rs
            mag = 32'((25'(man_sh) + 25'd1) >> 1);
        end
        if (i_depth_word[31]) begin
            d_q30 = -$signed({1'b0, mag});
        end else begin
            d_q30 = $signed({1'b0, mag});
        end
    end

    always_comb begin
        clip_bad = (i_near == 32'd0) || (i_far <= i_near);
        if (clip_bad) begin
            st_a = rzdm_pkg::ST_CLIP;
        end else if (ex == 8'hFF) begin
            st_a = rzdm_pkg::ST_DEPTH;
        end else if (i_depth_word[31] ? (i_depth_word[30:0] > rzdm_pkg::NEG_LIMIT)
                                      : (i_depth_word > rzdm_pkg::POS_LIMIT)) begin
            st_a = rzdm_pkg::ST_DEPTH;
        end else begin
            st_a = rzdm_pkg::ST_OK;
        end
    end

    // stage A: decoded depth
    logic               r_a_v;
    rzdm_pkg::t_pix     r_a_pix;
    rzdm_pkg::t_status  r_a_st;
    logic signed [32:0] r_a_d;

    // stage B: products
    logic               r_b_v;
    rzdm_pkg::t_pix     r_b_pix;
    rzdm_pkg::t_status  r_b_st;
    logic [63:0]        r_b_p;
    logic signed [63:0] r_b_pd;

    // stage C: denominator
    logic               r_c_v;
    rzdm_pkg::t_pix     r_c_pix;
    rzdm_pkg::t_status  r_c_st;
    logic [62:0]        r_c_den;
    logic [63:0]        r_c_rem;
    logic [1:0]         r_c_bits;

    // stage D: overflow check
    logic                r_d_v;
    rzdm_pkg::t_div_beat r_d_beat;

    logic [31:0]        diff;
    logic [63:0]        p_full;
    logic signed [65:0] pd_full;
    logic signed [64:0] den_full;
    rzdm_pkg::t_status  st_c;
    rzdm_pkg::t_div_beat n_d_beat;

    always_comb begin
        diff     = i_far - i_near;
        p_full   = 64'(i_near) * 64'(i_far);
        pd_full  = r_a_d * $signed({1'b0, diff});
        den_full = $signed({3'b000, i_near, 30'd0}) + $signed({r_b_pd[63], r_b_pd});
        st_c     = r_b_st;
        if (r_b_st == rzdm_pkg::ST_OK && (den_full[64] || den_full == '0)) begin
            st_c = rzdm_pkg::ST_METRIC;
        end
    end

    always_comb begin
        n_d_beat.pix    = r_c_pix;
        n_d_beat.status = r_c_st;
        // quotient would not fit 32 bits when p/4 >= den
        n_d_beat.sat    = r_c_rem >= {1'b0, r_c_den};
        n_d_beat.den    = r_c_den;
        n_d_beat.rem    = r_c_rem;
        n_d_beat.quo    = '0;
        n_d_beat.bits   = r_c_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (i_adv) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_pix  <= '{red: i_red, green: i_green, blue: i_blue, last: i_last};
            r_a_st   <= st_a;
            r_a_d    <= d_q30;

            r_b_pix  <= r_a_pix;
            r_b_st   <= r_a_st;
            r_b_p    <= p_full;
            r_b_pd   <= pd_full[63:0];

            r_c_pix  <= r_b_pix;
            r_c_st   <= st_c;
            r_c_den  <= den_full[62:0];
            r_c_rem  <= {2'b00, r_b_p[63:2]};
            r_c_bits <= r_b_p[1:0];

            r_d_beat <= n_d_beat;
        end
    end

    assign o_valid = r_d_v;
    assign o_beat  = r_d_beat;

    `RZDM_ASSERT_NEXT(a_clip_flagged, i_clk, i_rst_n, i_adv && i_valid && clip_bad, r_a_v && r_a_st == rzdm_pkg::ST_CLIP, "clip fault not flagged")

endmodule

// ===== rtl/core/rzdm_div_cell.sv =====
`include "reversed_z_depth_to_meters_macros.svh"

module rzdm_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  rzdm_pkg::t_div_beat  i_beat,
    output logic                 o_valid,
    output rzdm_pkg::t_div_beat  o_beat
);

    logic                r_valid;
    rzdm_pkg::t_div_beat r_beat;
    rzdm_pkg::t_div_beat n_beat;
    logic [63:0]         rem_sh;
    logic                q_bit;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        rem_sh      = {i_beat.rem[62:0], i_beat.bits[1]};
        q_bit       = rem_sh >= {1'b0, i_beat.den};
        n_beat      = i_beat;
        n_beat.rem  = q_bit ? (rem_sh - {1'b0, i_beat.den}) : rem_sh;
        n_beat.quo  = {i_beat.quo[rzdm_pkg::QUO_W-2:0], q_bit};
        n_beat.bits = {i_beat.bits[0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    `RZDM_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n, r_valid && r_beat.status == rzdm_pkg::ST_OK && !r_beat.sat, !r_beat.rem[63] && (r_beat.rem[62:0] < r_beat.den), "partial remainder escaped divisor")

endmodule

// ===== rtl/core/rzdm_back.sv =====
`include "reversed_z_depth_to_meters_macros.svh"

module rzdm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rzdm_pkg::t_div_beat  i_beat,
    output logic                 o_adv,
    rzdm_out_if.source           o_pix
);

    logic            r_out_v;
    rzdm_pkg::t_res  r_out;
    logic            r_skid_v;
    rzdm_pkg::t_res  r_skid;

    logic            n_out_v;
    rzdm_pkg::t_res  n_out;
    logic            n_skid_v;
    rzdm_pkg::t_res  n_skid;

    rzdm_pkg::t_res  res;
    logic            rnd;
    logic            take;
    logic            inc;

    // round to nearest, ties up: 2*rem >= den
    always_comb begin
        rnd        = {i_beat.rem[62:0], 1'b0} >= {1'b0, i_beat.den};
        res.pix    = i_beat.pix;
        res.status = i_beat.status;
        if (i_beat.status != rzdm_pkg::ST_OK) begin
            res.metres = '0;
        end else if (i_beat.sat || (&i_beat.quo && rnd)) begin
            res.metres = rzdm_pkg::SAT_Q16;
        end else begin
            res.metres = i_beat.quo + 32'(rnd);
        end
    end

    assign o_adv = !r_skid_v;
    assign take  = r_out_v && o_pix.ready;
    assign inc   = i_valid && !r_skid_v;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (take) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (!r_out_v || take) begin
            n_out_v = inc;
            n_out   = res;
        end else if (inc) begin
            n_skid_v = 1'b1;
            n_skid   = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_pix.valid        = r_out_v;
    assign o_pix.red_out      = r_out.pix.red;
    assign o_pix.green_out    = r_out.pix.green;
    assign o_pix.blue_out     = r_out.pix.blue;
    assign o_pix.depth_metres = r_out.metres;
    assign o_pix.status       = r_out.status;
    assign o_pix.last_out     = r_out.pix.last;

    `RZDM_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid beat without output beat")
    `RZDM_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_v && o_pix.ready, !r_skid_v && r_out_v, "skid beat not moved on")
    `RZDM_ASSERT_IMPL(a_zero_on_fault, i_clk, i_rst_n, r_out_v && r_out.status != rzdm_pkg::ST_OK, r_out.metres == '0, "faulted beat carries a depth")

endmodule

// ===== rtl/core/reversed_z_depth_to_meters.sv =====
// Throughput: one beat per cycle while ready is high; 4 front stages, then 32 divider
// cells, one per quotient bit, then the rounding stage into the output register.
// Ready drops only while the skid register holds a beat behind a stalled output.
// Reset (synchronous, active low) clears all valid flags and loads near = 1 m,
// far = 10000 m; no clearing pass.
module reversed_z_depth_to_meters (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    rzdm_in_if.sink     i_pix,
    rzdm_out_if.source  o_pix
);

    logic [31:0] r_near;
    logic [31:0] r_far;
    logic        adv;

    logic                cell_v [0:rzdm_pkg::QUO_W];
    rzdm_pkg::t_div_beat cell_b [0:rzdm_pkg::QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= rzdm_pkg::NEAR_RESET;
            r_far  <= rzdm_pkg::FAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rzdm_pkg::REG_NEAR: r_near <= i_cfg_data;
                rzdm_pkg::REG_FAR:  r_far  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_pix.ready = adv;

    rzdm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (i_pix.valid),
        .i_blue       (i_pix.blue_in),
        .i_green      (i_pix.green_in),
        .i_red        (i_pix.red_in),
        .i_depth_word (i_pix.depth_word),
        .i_last       (i_pix.last_in),
        .i_near       (r_near),
        .i_far        (r_far),
        .o_valid      (cell_v[0]),
        .o_beat       (cell_b[0])
    );

    for (genvar k = 0; k < rzdm_pkg::QUO_W; k++) begin : g_cell
        rzdm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (cell_v[k]),
            .i_beat  (cell_b[k]),
            .o_valid (cell_v[k+1]),
            .o_beat  (cell_b[k+1])
        );
    end

    rzdm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cell_v[rzdm_pkg::QUO_W]),
        .i_beat  (cell_b[rzdm_pkg::QUO_W]),
        .o_adv   (adv),
        .o_pix   (o_pix)
    );

endmodule
